// ===== design/swarq_pkg.sv =====
// Shared types, codes and constants of the stop-and-wait ARQ MAC header engine.
package swarq_pkg;

    localparam int ADDR_W        = 48;
    localparam int SEQ_W         = 32;
    localparam int TICKS_W       = 16;
    localparam int RETRY_CFG_W   = 4;
    localparam int RETRY_CNT_W   = 5;
    localparam int SEQ_BITS_DEF   = 32;
    localparam int TIMER_BITS_DEF = 16;

    localparam int S_TDATA_W = 176;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 128;
    localparam int M_TUSER_W = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] REQ_SEND = 2'd0;
    localparam logic [1:0] REQ_RX   = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;

    localparam logic [1:0] EV_TX      = 2'd0;
    localparam logic [1:0] EV_DROP    = 2'd1;
    localparam logic [1:0] EV_SUCCESS = 2'd2;
    localparam logic [1:0] EV_FAILURE = 2'd3;

    localparam logic FT_DATA = 1'b0;
    localparam logic FT_ACK  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 2'd2;

    localparam logic [ADDR_W-1:0]      OWN_ADDR_RST    = '0;
    localparam logic [RETRY_CFG_W-1:0] MAX_RETRIES_RST = 4'd3;
    localparam logic [TICKS_W-1:0]     ACK_TIMEOUT_RST = 16'd100;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [ADDR_W-1:0] dest_addr;
        logic              corrupted;
        logic              frame_type;
        logic [SEQ_W-1:0]  frame_seq;
        logic [ADDR_W-1:0] frame_src;
        logic [ADDR_W-1:0] frame_dst;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        out_event;
        logic              tx_type;
        logic [SEQ_W-1:0]  tx_seq;
        logic [ADDR_W-1:0] tx_src;
        logic [ADDR_W-1:0] tx_dst;
    } result_t;

    typedef struct packed {
        logic [ADDR_W-1:0]      own_address;
        logic [RETRY_CFG_W-1:0] max_retries;
        logic [TICKS_W-1:0]     ack_timeout_ticks;
    } cfg_t;

endpackage

// ===== design/swarq_cfg.sv =====
// Configuration register bank written through the configuration channel.
module swarq_cfg
    import swarq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_OWN_ADDR:    cfg_next.own_address       = cfg_data;
                CFG_MAX_RETRIES: cfg_next.max_retries       = cfg_data[RETRY_CFG_W-1:0];
                CFG_ACK_TIMEOUT: cfg_next.ack_timeout_ticks = cfg_data[TICKS_W-1:0];
                default:         cfg_next                   = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.own_address       <= OWN_ADDR_RST;
            cfg_reg.max_retries       <= MAX_RETRIES_RST;
            cfg_reg.ack_timeout_ticks <= ACK_TIMEOUT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/swarq_in_reg.sv =====
// Input register stage that holds one accepted item until the engine takes it.
module swarq_in_reg
    import swarq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    input  logic     advance,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

// ===== design/swarq_engine.sv =====
// ARQ protocol state and the per-item decision logic.
module swarq_engine
    import swarq_pkg::*;
#(
    parameter int SEQ_BITS   = SEQ_BITS_DEF,
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  cfg_t     cfg,
    input  logic     fire,
    input  in_item_t item,
    output logic     res_has,
    output result_t  res
);

    localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_BITS) - 33'd1;

    logic                   waiting_ack_reg, waiting_ack_next;
    logic [SEQ_BITS-1:0]    next_seq_reg, next_seq_next;
    logic [RETRY_CNT_W-1:0] retry_count_reg, retry_count_next;
    logic [ADDR_W-1:0]      pending_dst_reg, pending_dst_next;
    logic [SEQ_BITS-1:0]    pending_seq_reg, pending_seq_next;
    logic [TIMER_BITS-1:0]  ack_timer_reg, ack_timer_next;

    logic [32:0]            ticks_wide;
    logic [TIMER_BITS-1:0]  timer_load;
    logic [RETRY_CNT_W-1:0] retry_inc;

    always_comb begin
        ticks_wide = 33'(cfg.ack_timeout_ticks);
        timer_load = (ticks_wide > TIMER_MAX) ? TIMER_MAX[TIMER_BITS-1:0]
                                              : ticks_wide[TIMER_BITS-1:0];
        retry_inc  = retry_count_reg + RETRY_CNT_W'(1);
    end

    always_comb begin
        waiting_ack_next = waiting_ack_reg;
        next_seq_next    = next_seq_reg;
        retry_count_next = retry_count_reg;
        pending_dst_next = pending_dst_reg;
        pending_seq_next = pending_seq_reg;
        ack_timer_next   = ack_timer_reg;
        res_has          = 1'b0;
        res              = '0;
        case (item.req_type)
            REQ_SEND: begin
                res_has = 1'b1;
                if (waiting_ack_reg) begin
                    res.out_event = EV_DROP;
                end else begin
                    pending_seq_next = next_seq_reg;
                    next_seq_next    = next_seq_reg + SEQ_BITS'(1);
                    pending_dst_next = item.dest_addr;
                    waiting_ack_next = 1'b1;
                    ack_timer_next   = timer_load;
                    res.out_event    = EV_TX;
                    res.tx_type      = FT_DATA;
                    res.tx_seq       = SEQ_W'(next_seq_reg);
                    res.tx_src       = cfg.own_address;
                    res.tx_dst       = item.dest_addr;
                end
            end
            REQ_RX: begin
                if (item.corrupted) begin
                    res_has       = 1'b1;
                    res.out_event = EV_DROP;
                end else if (item.frame_dst == cfg.own_address) begin
                    if (item.frame_type == FT_DATA) begin
                        res_has       = 1'b1;
                        res.out_event = EV_TX;
                        res.tx_type   = FT_ACK;
                        res.tx_seq    = item.frame_seq;
                        res.tx_src    = cfg.own_address;
                        res.tx_dst    = item.frame_src;
                    end else if (waiting_ack_reg
                                 && item.frame_seq[SEQ_BITS-1:0] == pending_seq_reg) begin
                        waiting_ack_next = 1'b0;
                        retry_count_next = '0;
                        ack_timer_next   = '0;
                        res_has          = 1'b1;
                        res.out_event    = EV_SUCCESS;
                        res.tx_type      = FT_DATA;
                        res.tx_seq       = SEQ_W'(pending_seq_reg);
                        res.tx_src       = cfg.own_address;
                        res.tx_dst       = pending_dst_reg;
                    end
                end
            end
            REQ_TICK: begin
                if (waiting_ack_reg) begin
                    if (ack_timer_reg > TIMER_BITS'(1)) begin
                        ack_timer_next = ack_timer_reg - TIMER_BITS'(1);
                    end else begin
                        res_has     = 1'b1;
                        res.tx_type = FT_DATA;
                        res.tx_seq  = SEQ_W'(pending_seq_reg);
                        res.tx_src  = cfg.own_address;
                        res.tx_dst  = pending_dst_reg;
                        if (retry_inc > RETRY_CNT_W'(cfg.max_retries)) begin
                            waiting_ack_next = 1'b0;
                            retry_count_next = '0;
                            ack_timer_next   = '0;
                            res.out_event    = EV_FAILURE;
                        end else begin
                            retry_count_next = retry_inc;
                            ack_timer_next   = timer_load;
                            res.out_event    = EV_TX;
                        end
                    end
                end
            end
            default: begin
                res_has = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            waiting_ack_reg <= 1'b0;
            next_seq_reg    <= '0;
            retry_count_reg <= '0;
            pending_dst_reg <= '0;
            pending_seq_reg <= '0;
            ack_timer_reg   <= '0;
        end else if (fire) begin
            waiting_ack_reg <= waiting_ack_next;
            next_seq_reg    <= next_seq_next;
            retry_count_reg <= retry_count_next;
            pending_dst_reg <= pending_dst_next;
            pending_seq_reg <= pending_seq_next;
            ack_timer_reg   <= ack_timer_next;
        end
    end

endmodule

// ===== design/swarq_out_reg.sv =====
// Result register that holds one header event until the receiver takes it.
module swarq_out_reg
    import swarq_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    output logic    can_load,
    input  logic    fire,
    input  logic    res_has,
    input  result_t res,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign can_load = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_res    = res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (can_load) begin
            valid_next = fire && res_has;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && res_has) begin
            res_reg <= res;
        end
    end

endmodule

// ===== design/stop_wait_arq_mac.sv =====
// Top level of the stop-and-wait ARQ MAC header engine.
// The s_ channel carries events: send requests, received frame headers and
// timer ticks, selected by the request type in s_tuser. The m_ channel
// carries the resulting header events: a data or ACK header to transmit, a
// dropped request or frame, or the success or failure of a pending send.
// An event gives at most one result; ignored frames and most ticks give none.
// The cfg_ channel writes own address, retry limit and ACK timeout; it is
// always ready. The user must write it only while no event is in flight;
// the block does not enforce it. A result passes the input register, then
// the result register. Throughput: one event per cycle while the receiver
// does not stall, set by the single pass of decision logic between the two
// registers. When the receiver stalls, the result register holds its
// transfer and the input register takes one more event; s_tready drops
// only while both are full. Reset clears both stages, the protocol state
// (idle, sequence 0, no retries) and restores the configuration defaults.
module stop_wait_arq_mac
    import swarq_pkg::*;
#(
    parameter int SEQ_BITS   = SEQ_BITS_DEF,
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // dest_addr, frame_seq, frame_src, frame_dst
    input  logic [S_TDATA_W-1:0] s_tdata,
    // req_type, corrupted, frame_type
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // tx_seq, tx_src, tx_dst
    output logic [M_TDATA_W-1:0] m_tdata,
    // out_event, tx_type
    output logic [M_TUSER_W-1:0] m_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    cfg_t     cfg;
    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     can_load;
    logic     fire;
    logic     res_has;
    result_t  res;
    result_t  m_res;

    always_comb begin
        s_item.req_type   = s_tuser[1:0];
        s_item.corrupted  = s_tuser[2];
        s_item.frame_type = s_tuser[3];
        s_item.dest_addr  = s_tdata[47:0];
        s_item.frame_seq  = s_tdata[79:48];
        s_item.frame_src  = s_tdata[127:80];
        s_item.frame_dst  = s_tdata[175:128];
    end

    assign fire    = item_valid && can_load;
    assign m_tdata = {m_res.tx_dst, m_res.tx_src, m_res.tx_seq};
    assign m_tuser = {m_res.tx_type, m_res.out_event};

    swarq_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    swarq_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .advance    (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    swarq_engine #(
        .SEQ_BITS   (SEQ_BITS),
        .TIMER_BITS (TIMER_BITS)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .fire    (fire),
        .item    (item),
        .res_has (res_has),
        .res     (res)
    );

    swarq_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .can_load (can_load),
        .fire     (fire),
        .res_has  (res_has),
        .res      (res),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_res    (m_res)
    );

`ifndef SYNTH
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while result register can take a transfer");

    a_drop_is_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_res.out_event == EV_DROP) |-> (m_tdata == '0 && !m_res.tx_type))
        else $error("dropped result carries header fields");

    a_src_is_own: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_res.out_event != EV_DROP) |-> (m_res.tx_src == cfg.own_address))
        else $error("transmitted header source differs from own address");
`endif

endmodule
